// ----- rtl/mnat_pkg.sv -----
// Shared types, widths and codes for the MIDI note activity tracker.
// Used by every module of the block; depends on nothing else.
package mnat_pkg;

    localparam int NOTES  = 128;
    localparam int NOTE_W = 7;
    localparam int VEL_W  = 7;
    localparam int CNT_W  = 8;
    localparam int GEN_W  = 32;
    localparam int ACT_W  = 2;
    localparam int OP_W   = 2;
    localparam int ADDR_W = (NOTES > 1) ? $clog2(NOTES) : 1;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Action codes as they arrive on the input port.
    localparam logic [ACT_W-1:0] ACT_ON      = 2'd0;
    localparam logic [ACT_W-1:0] ACT_OFF     = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ALL_OFF = 2'd2;
    localparam logic [ACT_W-1:0] ACT_QUERY   = 2'd3;

    // Operation codes after classification by the front end.
    localparam logic [OP_W-1:0] OP_ON    = 2'd0;
    localparam logic [OP_W-1:0] OP_OFF   = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd3;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [NOTE_W-1:0] note;
        logic [VEL_W-1:0]  vel;
        logic              in_range;
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [VEL_W-1:0] vel;
        logic [GEN_W-1:0] gen;
    } entry_t;

    localparam entry_t ENTRY_RESET = '{cnt: '0, vel: '0, gen: GEN_W'(1)};

endpackage

// ----- rtl/midi_note_activity_tracker_top.sv -----
// Top level of the MIDI note activity tracker.
// Depends on mnat_pkg, mnat_front, mnat_queue and mnat_back.
//
// Channel   Direction  Handshake           Payload
// command   in         start / busy        action, note, velocity
// result    out        done (one cycle)    note_velocity, note_generation, held_count
//
// A command beat is taken at a rising edge where start is high and busy is low.
// Busy is high only while the two-entry command queue is full.
// A note-on, note-off or query goes through the back-end states in order (take from
// the queue, table read into a register, update and write); its result strobes in
// the cycle after the update. An all-off sweeps every table entry, reading and then
// writing each in turn, then reports the addressed note.
// Reset is asynchronous and needs no clearing pass: per-note valid bits make
// unwritten entries read as count zero, velocity zero, change counter one.
// The receiver cannot stall; done is high for one cycle and the result values then hold.
module midi_note_activity_tracker_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [mnat_pkg::ACT_W-1:0]   action,
    input  logic [mnat_pkg::NOTE_W-1:0]  note,
    input  logic [mnat_pkg::VEL_W-1:0]   velocity,
    output logic                         done,
    output logic [mnat_pkg::VEL_W-1:0]   note_velocity,
    output logic [mnat_pkg::GEN_W-1:0]   note_generation,
    output logic [mnat_pkg::CNT_W-1:0]   held_count
);

    mnat_pkg::cmd_t in_cmd;
    mnat_pkg::cmd_t head_cmd;
    logic           q_empty;
    logic           q_full;
    logic           q_pop;
    logic           q_push;

    // The front end turns a raw beat into an operation: a zero-velocity note-on
    // becomes a release, and notes beyond the table are flagged out of range.
    mnat_front u_front (
        .action   (action),
        .note     (note),
        .velocity (velocity),
        .cmd      (in_cmd)
    );

    assign busy   = q_full;
    assign q_push = start && !q_full;

    mnat_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (in_cmd),
        .pop      (q_pop),
        .head_cmd (head_cmd),
        .empty    (q_empty),
        .full     (q_full)
    );

    // The back end owns the note table and produces one result per command.
    mnat_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_cmd           (head_cmd),
        .q_empty         (q_empty),
        .pop             (q_pop),
        .done            (done),
        .note_velocity   (note_velocity),
        .note_generation (note_generation),
        .held_count      (held_count)
    );

endmodule

// ----- rtl/mnat_front.sv -----
// Front end: classifies an incoming beat into an operation for the back end.
// Depends on mnat_pkg.
module mnat_front (
    input  logic [mnat_pkg::ACT_W-1:0]  action,
    input  logic [mnat_pkg::NOTE_W-1:0] note,
    input  logic [mnat_pkg::VEL_W-1:0]  velocity,
    output mnat_pkg::cmd_t              cmd
);

    logic [mnat_pkg::OP_W-1:0] op;

    // A note-on with zero velocity is a release.
    always_comb
    begin
        case (action)
            mnat_pkg::ACT_ON:
                op = (velocity == '0) ? mnat_pkg::OP_OFF : mnat_pkg::OP_ON;
            mnat_pkg::ACT_OFF:     op = mnat_pkg::OP_OFF;
            mnat_pkg::ACT_ALL_OFF: op = mnat_pkg::OP_CLEAR;
            mnat_pkg::ACT_QUERY:   op = mnat_pkg::OP_QUERY;
            default:               op = mnat_pkg::OP_QUERY;
        endcase
    end

    assign cmd.op       = op;
    assign cmd.note     = note;
    assign cmd.vel      = velocity;
    assign cmd.in_range = ({1'b0, note} < (mnat_pkg::NOTE_W + 1)'(mnat_pkg::NOTES));

endmodule

// ----- rtl/mnat_queue.sv -----
// Short command queue between the front end and the back end.
// Depends on mnat_pkg.
module mnat_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  mnat_pkg::cmd_t push_cmd,
    input  logic           pop,
    output mnat_pkg::cmd_t head_cmd,
    output logic           empty,
    output logic           full
);

    mnat_pkg::cmd_t slot_reg [mnat_pkg::QDEPTH];

    logic [mnat_pkg::QPTR_W-1:0] wptr_reg, wptr_next;
    logic [mnat_pkg::QPTR_W-1:0] rptr_reg, rptr_next;
    logic [mnat_pkg::QCNT_W-1:0] count_reg, count_next;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == mnat_pkg::QCNT_W'(mnat_pkg::QDEPTH));
    assign head_cmd = slot_reg[rptr_reg];

    always_comb
    begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (push)
        begin
            wptr_next = (wptr_reg == mnat_pkg::QPTR_W'(mnat_pkg::QDEPTH - 1)) ?
                        '0 : wptr_reg + 1'b1;
        end
        if (pop)
        begin
            rptr_next = (rptr_reg == mnat_pkg::QPTR_W'(mnat_pkg::QDEPTH - 1)) ?
                        '0 : rptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_cmd;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= mnat_pkg::QCNT_W'(mnat_pkg::QDEPTH))
        else $error("queue fill count beyond depth");
`endif

endmodule

// ----- rtl/mnat_back.sv -----
// Back end: read-modify-write of the per-note table and result delivery.
// Depends on mnat_pkg; holds the note table memory and its valid bits.
module mnat_back (
    input  logic                         clk,
    input  logic                         rst_n,
    input  mnat_pkg::cmd_t               q_cmd,
    input  logic                         q_empty,
    output logic                         pop,
    output logic                         done,
    output logic [mnat_pkg::VEL_W-1:0]   note_velocity,
    output logic [mnat_pkg::GEN_W-1:0]   note_generation,
    output logic [mnat_pkg::CNT_W-1:0]   held_count
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_MOD  = 2'd2;

    localparam logic [mnat_pkg::ADDR_W-1:0] LAST_ADDR =
        mnat_pkg::ADDR_W'(mnat_pkg::NOTES - 1);

    mnat_pkg::entry_t mem [mnat_pkg::NOTES];
    mnat_pkg::entry_t rdata_reg;
    logic             rvld_reg;
    logic [mnat_pkg::NOTES-1:0] vld_reg;

    logic [1:0]                  state_reg, state_next;
    mnat_pkg::cmd_t              cmd_reg, cmd_next;
    logic [mnat_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic                        done_reg, done_next;
    logic [mnat_pkg::VEL_W-1:0]  vel_out_reg, vel_out_next;
    logic [mnat_pkg::GEN_W-1:0]  gen_out_reg, gen_out_next;
    logic [mnat_pkg::CNT_W-1:0]  cnt_out_reg, cnt_out_next;

    mnat_pkg::entry_t            cur;
    mnat_pkg::entry_t            upd;
    logic [mnat_pkg::CNT_W-1:0]  dec_cnt;
    logic                        we;
    logic                        rd_en;
    logic [mnat_pkg::ADDR_W-1:0] note_addr;

    assign note_addr = q_cmd.note[mnat_pkg::ADDR_W-1:0];

    // Entries never written since reset read as their reset value.
    assign cur     = rvld_reg ? rdata_reg : mnat_pkg::ENTRY_RESET;
    assign dec_cnt = (cur.cnt != '0) ? cur.cnt - 1'b1 : '0;

    always_comb
    begin
        upd = cur;
        case (cmd_reg.op)
            mnat_pkg::OP_ON:
            begin
                upd.cnt = (cur.cnt == mnat_pkg::CNT_MAX) ? cur.cnt : cur.cnt + 1'b1;
                upd.vel = cmd_reg.vel;
                upd.gen = cur.gen + 1'b1;
            end
            mnat_pkg::OP_OFF:
            begin
                upd.cnt = dec_cnt;
                if (dec_cnt == '0)
                begin
                    upd.vel = '0;
                    upd.gen = cur.gen + 1'b1;
                end
            end
            mnat_pkg::OP_CLEAR:
            begin
                upd.cnt = '0;
                upd.vel = '0;
                upd.gen = cur.gen + 1'b1;
            end
            default:
            begin
                upd = cur;
            end
        endcase
    end

    assign rd_en = (state_reg == ST_RD);
    assign we    = (state_reg == ST_MOD) &&
                   ((cmd_reg.op == mnat_pkg::OP_CLEAR) ||
                    (cmd_reg.in_range && ((cmd_reg.op == mnat_pkg::OP_ON) ||
                                          (cmd_reg.op == mnat_pkg::OP_OFF))));
    assign pop   = (state_reg == ST_IDLE) && !q_empty;

    always_comb
    begin
        state_next   = state_reg;
        cmd_next     = cmd_reg;
        addr_next    = addr_reg;
        done_next    = 1'b0;
        vel_out_next = vel_out_reg;
        gen_out_next = gen_out_reg;
        cnt_out_next = cnt_out_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    cmd_next   = q_cmd;
                    addr_next  = (q_cmd.op == mnat_pkg::OP_CLEAR) ? '0 : note_addr;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_MOD;
            end
            ST_MOD:
            begin
                if (cmd_reg.op == mnat_pkg::OP_CLEAR)
                begin
                    state_next = ST_RD;
                    if (addr_reg == LAST_ADDR)
                    begin
                        // Sweep finished: report the addressed note.
                        cmd_next.op = mnat_pkg::OP_QUERY;
                        addr_next   = cmd_reg.note[mnat_pkg::ADDR_W-1:0];
                    end
                    else
                    begin
                        addr_next = addr_reg + 1'b1;
                    end
                end
                else
                begin
                    state_next   = ST_IDLE;
                    done_next    = 1'b1;
                    vel_out_next = cmd_reg.in_range ? upd.vel : '0;
                    gen_out_next = cmd_reg.in_range ? upd.gen : '0;
                    cnt_out_next = cmd_reg.in_range ? upd.cnt : '0;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
            vld_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            if (we)
            begin
                vld_reg[addr_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        addr_reg    <= addr_next;
        vel_out_reg <= vel_out_next;
        gen_out_reg <= gen_out_next;
        cnt_out_reg <= cnt_out_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr_reg] <= upd;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[addr_reg];
            rvld_reg  <= vld_reg[addr_reg];
        end
    end

    assign done            = done_reg;
    assign note_velocity   = vel_out_reg;
    assign note_generation = gen_out_reg;
    assign held_count      = cnt_out_reg;

`ifndef SYNTH
    a_done_after_mod: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(state_reg) == ST_MOD))
        else $error("result strobe without a preceding update cycle");

    a_idle_velocity: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && (cnt_out_reg == '0)) |-> (vel_out_reg == '0))
        else $error("velocity reported for a note with nothing held");

    a_pop_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg == ST_RD))
        else $error("command taken from queue but no table read followed");
`endif

endmodule
